// File: hw/rtl/iaf_pkg.sv
// ----------------------------------------------------------------------------
// iaf_pkg: shared types and constants for the integer to ASCII formatter
// Base codes, format options, status groups, ASCII codes and digit mapping.
// ----------------------------------------------------------------------------
package iaf_pkg;

  // number base selected by the mode field
  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_HEX = 2'd1,
    MODE_BIN = 2'd2,
    MODE_OCT = 2'd3
  } base_mode_t;

  // controller states of the top level
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_CONV,
    TOP_EMIT
  } top_state_t;

  // digit generator states
  typedef enum logic [1:0] {
    DG_IDLE,
    DG_DABBLE,
    DG_SPLIT
  } dg_state_t;

  // text emitter states
  typedef enum logic [2:0] {
    EM_IDLE,
    EM_SIZE,
    EM_PLAN,
    EM_BOUND,
    EM_RUN
  } em_state_t;

  localparam int DIGITS_MAX  = 64;  // binary digits of a 64-bit magnitude
  localparam int DIGIT_CNT_W = 7;   // holds 0..64
  localparam int BCD_DIGITS  = 20;  // decimal digits of 2^64-1
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int VALUE_W     = 64;
  localparam int TEXT_W      = 8;   // text positions and lengths
  localparam int CHAR_SLOTS  = 8;   // character ports per result
  localparam int SLOT_W      = 3;
  localparam int COUNT_W     = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;

  // format options held for the duration of one request
  typedef struct packed {
    base_mode_t mode;
    logic       upper_case;
    logic       alt_prefix;
    logic       plus_sign;
    logic       space_sign;
    logic       zero_pad;
    logic       left_align;
    logic [6:0] field_width;
  } fmt_opts_t;

  // digit generator to emitter
  typedef struct packed {
    logic                   done;
    logic                   neg;
    logic [DIGIT_CNT_W-1:0] nd;
  } dg_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] dz;
    dz = {4'h0, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + dz;
    end else begin
      digit_char = (upper ? CH_A_UP : CH_A_LO) + dz - 8'd10;
    end
  endfunction

endpackage

// File: hw/rtl/iaf_digit_gen.sv
// ----------------------------------------------------------------------------
// iaf_digit_gen: magnitude and digit generation
// Bit-serial binary to BCD (shift and add 3) for decimal, then one digit per
// cycle pushed onto a digit stack, least significant first; pops give MSD first.
// ----------------------------------------------------------------------------
module iaf_digit_gen (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [63:0]           value,
  input  logic                  is_signed,
  input  logic                  is_wide,
  input  iaf_pkg::base_mode_t   mode,
  input  logic                  pop,
  output iaf_pkg::dg_status_t   status,
  output logic [3:0]            top_digit
);

  iaf_pkg::dg_state_t state, state_next;

  logic [iaf_pkg::VALUE_W-1:0]     mag;
  logic [iaf_pkg::BCD_W-1:0]       bcd;
  logic [6:0]                      steps;
  iaf_pkg::base_mode_t             base;
  logic                            neg;
  logic                            done;
  logic [iaf_pkg::DIGIT_CNT_W-1:0] nd;
  logic [3:0]                      stack [iaf_pkg::DIGITS_MAX];

  logic                        sign_bit;
  logic                        neg_ld;
  logic [iaf_pkg::VALUE_W-1:0] raw;
  logic [iaf_pkg::VALUE_W-1:0] abs_val;
  logic [iaf_pkg::VALUE_W-1:0] mag_ld;
  logic [iaf_pkg::BCD_W-1:0]   bcd_adj;
  logic [3:0]                  digit;
  logic                        rest_zero;
  logic [iaf_pkg::VALUE_W-1:0] mag_split;
  logic                        is_dec;

  // magnitude of the incoming value, narrow values kept in the low half
  assign is_dec   = (mode == iaf_pkg::MODE_DEC);
  assign sign_bit = is_wide ? value[63] : value[31];
  assign neg_ld   = is_signed & sign_bit;
  assign raw      = is_wide ? value : {32'h0, value[31:0]};

  always_comb begin
    abs_val = neg_ld ? (~raw + 64'd1) : raw;
    if (!is_wide) begin
      abs_val[63:32] = 32'h0;
    end
    // decimal narrow: align to the top so only 32 shift steps are needed
    mag_ld = (is_dec && !is_wide) ? {abs_val[31:0], 32'h0} : abs_val;
  end

  // add 3 to every BCD digit of 5 or more
  always_comb begin
    for (int i = 0; i < iaf_pkg::BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3)
                                                  : bcd[4*i +: 4];
    end
  end

  // next digit, least significant first
  always_comb begin
    digit     = 4'h0;
    rest_zero = 1'b1;
    mag_split = mag;
    case (base)
      iaf_pkg::MODE_HEX: begin
        digit     = mag[3:0];
        rest_zero = (mag[63:4] == 60'h0);
        mag_split = mag >> 4;
      end
      iaf_pkg::MODE_OCT: begin
        digit     = {1'b0, mag[2:0]};
        rest_zero = (mag[63:3] == 61'h0);
        mag_split = mag >> 3;
      end
      iaf_pkg::MODE_BIN: begin
        digit     = {3'b000, mag[0]};
        rest_zero = (mag[63:1] == 63'h0);
        mag_split = mag >> 1;
      end
      default: begin
        digit     = bcd[3:0];
        rest_zero = (bcd[iaf_pkg::BCD_W-1:4] == '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iaf_pkg::DG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == iaf_pkg::DG_SPLIT) && rest_zero;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iaf_pkg::DG_IDLE: begin
        if (load) begin
          state_next = is_dec ? iaf_pkg::DG_DABBLE : iaf_pkg::DG_SPLIT;
        end
      end
      iaf_pkg::DG_DABBLE: begin
        if (steps == 7'd1) begin
          state_next = iaf_pkg::DG_SPLIT;
        end
      end
      iaf_pkg::DG_SPLIT: begin
        if (rest_zero) begin
          state_next = iaf_pkg::DG_IDLE;
        end
      end
      default: state_next = iaf_pkg::DG_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == iaf_pkg::DG_IDLE && load) begin
      mag   <= mag_ld;
      bcd   <= '0;
      steps <= is_wide ? 7'd64 : 7'd32;
      base  <= mode;
      neg   <= neg_ld;
      nd    <= '0;
    end else if (state == iaf_pkg::DG_DABBLE) begin
      bcd   <= {bcd_adj[iaf_pkg::BCD_W-2:0], mag[63]};
      mag   <= mag << 1;
      steps <= steps - 7'd1;
    end else if (state == iaf_pkg::DG_SPLIT) begin
      mag <= mag_split;
      bcd <= bcd >> 4;
      nd  <= nd + 7'd1;
    end
  end

  // digit stack: push at the split step, pop while the emitter writes digits
  always_ff @(posedge clk) begin
    if (state == iaf_pkg::DG_SPLIT) begin
      stack[0] <= digit;
      for (int i = 1; i < iaf_pkg::DIGITS_MAX; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < iaf_pkg::DIGITS_MAX - 1; i++) begin
        stack[i] <= stack[i+1];
      end
      stack[iaf_pkg::DIGITS_MAX-1] <= 4'h0;
    end
  end

  assign top_digit   = stack[0];
  assign status.done = done;
  assign status.neg  = neg;
  assign status.nd   = nd;

endmodule

// File: hw/rtl/iaf_emitter.sv
// ----------------------------------------------------------------------------
// iaf_emitter: text layout and grouping
// Works out field boundaries, then writes one character per cycle into a
// group buffer and presents each full (or final) group for one cycle.
// ----------------------------------------------------------------------------
module iaf_emitter #(
  parameter int MAX_WIDTH        = 127,
  parameter int CHARS_PER_RESULT = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         launch,
  input  iaf_pkg::fmt_opts_t           opts,
  input  iaf_pkg::dg_status_t          dg,
  input  logic [3:0]                   top_digit,
  output logic                         pop,
  output logic                         finished,
  output logic [7:0]                   chars [iaf_pkg::CHAR_SLOTS],
  output logic [iaf_pkg::COUNT_W-1:0]  char_count,
  output logic                         last_group,
  output logic                         strobe
);

  localparam int TW = iaf_pkg::TEXT_W;

  iaf_pkg::em_state_t state, state_next;

  logic [TW-1:0] body, total, lead, b_pre, b_zero, b_dig, b_trail, pos;
  logic [iaf_pkg::SLOT_W-1:0] slot;
  logic [7:0] wbuf [iaf_pkg::CHAR_SLOTS];
  logic [7:0] nbuf [iaf_pkg::CHAR_SLOTS];

  logic          sgnlen;
  logic [1:0]    prelen;
  logic [TW-1:0] width;
  logic [TW-1:0] body0;
  logic [TW-1:0] nd_w;
  logic [7:0]    ch;
  logic [7:0]    sign_ch;
  logic [7:0]    pre2_ch;
  logic          last_char;
  logic          grp_full;
  logic          emit;

  assign nd_w   = {1'b0, dg.nd};
  assign sgnlen = dg.neg | opts.plus_sign | opts.space_sign;
  assign width  = ({1'b0, opts.field_width} > TW'(MAX_WIDTH)) ? TW'(MAX_WIDTH)
                                                              : {1'b0, opts.field_width};

  always_comb begin
    prelen = 2'd0;
    if (opts.alt_prefix) begin
      case (opts.mode) inside
        iaf_pkg::MODE_HEX, iaf_pkg::MODE_BIN: prelen = 2'd2;
        iaf_pkg::MODE_OCT:                    prelen = 2'd1;
        default:                              prelen = 2'd0;
      endcase
    end
  end

  assign body0 = nd_w + TW'(prelen) + TW'(sgnlen);

  assign sign_ch = dg.neg ? iaf_pkg::CH_MINUS
                 : (opts.plus_sign ? iaf_pkg::CH_PLUS : iaf_pkg::CH_SPACE);
  assign pre2_ch = (opts.mode == iaf_pkg::MODE_HEX)
                 ? (opts.upper_case ? iaf_pkg::CH_X_UP : iaf_pkg::CH_X_LO)
                 : iaf_pkg::CH_B_LO;

  // character at the current position
  always_comb begin
    pop = 1'b0;
    if (pos < lead) begin
      ch = iaf_pkg::CH_SPACE;
    end else if (pos < b_pre) begin
      ch = sign_ch;
    end else if (pos < b_zero) begin
      ch = (pos == b_pre) ? iaf_pkg::CH_ZERO : pre2_ch;
    end else if (pos < b_dig) begin
      ch = iaf_pkg::CH_ZERO;
    end else if (pos < b_trail) begin
      ch  = iaf_pkg::digit_char(top_digit, opts.upper_case);
      pop = (state == iaf_pkg::EM_RUN);
    end else begin
      ch = iaf_pkg::CH_SPACE;
    end
  end

  assign emit      = (state == iaf_pkg::EM_RUN);
  assign last_char = (pos == total - TW'(1));
  assign grp_full  = (slot == iaf_pkg::SLOT_W'(CHARS_PER_RESULT - 1));
  assign finished  = emit && last_char;

  always_comb begin
    for (int j = 0; j < iaf_pkg::CHAR_SLOTS; j++) begin
      nbuf[j] = wbuf[j];
    end
    nbuf[slot] = ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= iaf_pkg::EM_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit && (grp_full || last_char);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iaf_pkg::EM_IDLE:  if (launch) state_next = iaf_pkg::EM_SIZE;
      iaf_pkg::EM_SIZE:  state_next = iaf_pkg::EM_PLAN;
      iaf_pkg::EM_PLAN:  state_next = iaf_pkg::EM_BOUND;
      iaf_pkg::EM_BOUND: state_next = iaf_pkg::EM_RUN;
      iaf_pkg::EM_RUN:   if (last_char) state_next = iaf_pkg::EM_IDLE;
      default:           state_next = iaf_pkg::EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      iaf_pkg::EM_SIZE: begin
        // zero padding widens the body itself
        body <= (opts.zero_pad && (width > body0)) ? width : body0;
      end
      iaf_pkg::EM_PLAN: begin
        total <= (width > body) ? width : body;
        lead  <= (!opts.left_align && (width > body)) ? (width - body) : '0;
      end
      iaf_pkg::EM_BOUND: begin
        b_pre   <= lead + TW'(sgnlen);
        b_zero  <= lead + TW'(sgnlen) + TW'(prelen);
        b_dig   <= lead + body - nd_w;
        b_trail <= lead + body;
        pos     <= '0;
        slot    <= '0;
        for (int j = 0; j < iaf_pkg::CHAR_SLOTS; j++) begin
          wbuf[j] <= 8'h00;
        end
      end
      iaf_pkg::EM_RUN: begin
        pos <= pos + TW'(1);
        if (grp_full || last_char) begin
          for (int j = 0; j < iaf_pkg::CHAR_SLOTS; j++) begin
            chars[j] <= nbuf[j];
            wbuf[j]  <= 8'h00;
          end
          char_count <= {1'b0, slot} + iaf_pkg::COUNT_W'(1);
          last_group <= last_char;
          slot       <= '0;
        end else begin
          for (int j = 0; j < iaf_pkg::CHAR_SLOTS; j++) begin
            wbuf[j] <= nbuf[j];
          end
          slot <= slot + iaf_pkg::SLOT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: printf-style integer to ASCII text
// Decimal runs 64 (32 for narrow values) shift steps before splitting digits;
//   hex/octal/binary split digits directly; the emitter then sets up in SIZE, PLAN, BOUND.
// Text leaves at one character per cycle, a result every CHARS_PER_RESULT
//   characters; the digit loop and the character loop set how long a request takes.
// One request at a time; busy drops in the cycle of the final result.
// Synchronous active-high reset returns all controllers to idle, no strobe.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core #(
  parameter int MAX_WIDTH        = 127,
  parameter int CHARS_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic        is_signed,
  input  logic        is_wide,
  input  logic [1:0]  mode,
  input  logic        upper_case,
  input  logic        alt_prefix,
  input  logic        plus_sign,
  input  logic        space_sign,
  input  logic        zero_pad,
  input  logic        left_align,
  input  logic [6:0]  field_width,
  // result side, one cycle per group, cannot be stalled
  output logic        strobe,
  output logic [7:0]  char0,
  output logic [7:0]  char1,
  output logic [7:0]  char2,
  output logic [7:0]  char3,
  output logic [7:0]  char4,
  output logic [7:0]  char5,
  output logic [7:0]  char6,
  output logic [7:0]  char7,
  output logic [3:0]  char_count,
  output logic        last_group
);

  iaf_pkg::top_state_t state, state_next;
  iaf_pkg::fmt_opts_t  opts;
  iaf_pkg::dg_status_t dg_status;

  logic       accept;
  logic       pop;
  logic       em_finished;
  logic [3:0] top_digit;
  logic [7:0] chars [iaf_pkg::CHAR_SLOTS];

  // a request is taken when start meets an idle block
  assign accept = start && !busy;
  assign busy   = (state != iaf_pkg::TOP_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iaf_pkg::TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request controller: convert, then emit text, then back to idle
  always_comb begin
    state_next = state;
    unique case (state)
      iaf_pkg::TOP_IDLE: if (accept)         state_next = iaf_pkg::TOP_CONV;
      iaf_pkg::TOP_CONV: if (dg_status.done) state_next = iaf_pkg::TOP_EMIT;
      iaf_pkg::TOP_EMIT: if (em_finished)    state_next = iaf_pkg::TOP_IDLE;
      default:                               state_next = iaf_pkg::TOP_IDLE;
    endcase
  end

  // format options held for the whole request
  always_ff @(posedge clk) begin
    if (accept) begin
      opts.mode        <= iaf_pkg::base_mode_t'(mode);
      opts.upper_case  <= upper_case;
      opts.alt_prefix  <= alt_prefix;
      opts.plus_sign   <= plus_sign;
      opts.space_sign  <= space_sign;
      opts.zero_pad    <= zero_pad;
      opts.left_align  <= left_align;
      opts.field_width <= field_width;
    end
  end

  // digit generation: magnitude, shift-and-add-3 BCD, digit stack
  iaf_digit_gen u_digit_gen (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .value     (value),
    .is_signed (is_signed),
    .is_wide   (is_wide),
    .mode      (iaf_pkg::base_mode_t'(mode)),
    .pop       (pop),
    .status    (dg_status),
    .top_digit (top_digit)
  );

  // padding, sign, prefix, digits; grouped into results
  iaf_emitter #(
    .MAX_WIDTH        (MAX_WIDTH),
    .CHARS_PER_RESULT (CHARS_PER_RESULT)
  ) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .launch     (dg_status.done),
    .opts       (opts),
    .dg         (dg_status),
    .top_digit  (top_digit),
    .pop        (pop),
    .finished   (em_finished),
    .chars      (chars),
    .char_count (char_count),
    .last_group (last_group),
    .strobe     (strobe)
  );

  assign char0 = chars[0];
  assign char1 = chars[1];
  assign char2 = chars[2];
  assign char3 = chars[3];
  assign char4 = chars[4];
  assign char5 = chars[5];
  assign char6 = chars[6];
  assign char7 = chars[7];

endmodule

// File: hw/rtl/iaf_checker.sv
// ----------------------------------------------------------------------------
// iaf_checker: port-level checks for the formatter core
// Request acceptance, result counts and group ordering seen at the ports.
// ----------------------------------------------------------------------------
module iaf_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [3:0] char_count,
  input logic       last_group
);

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // every result carries one to eight characters
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (char_count != 4'd0) && (char_count <= 4'd8))
    else $error("char_count out of range");

  // more groups to come means the request is still in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_group |-> busy)
    else $error("intermediate group while idle");

  // nothing follows the final group straight away
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last_group |=> !strobe)
    else $error("result straight after final group");

endmodule

bind integer_to_ascii_formatter_core iaf_checker u_iaf_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .char_count (char_count),
  .last_group (last_group)
);
